// File: design/tlpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page translator.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int VA_W     = 32;
	localparam int OFF_W    = 5;
	localparam int LVL_W    = 4;
	localparam int FCNT_W   = 9;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 2;
	localparam int STAMP_W  = 64;
	localparam int CNT_W    = 32;

	localparam logic [OFF_W-1:0]  OFF_RST  = 5'd12;
	localparam logic [LVL_W-1:0]  LVL_RST  = 4'd10;
	localparam logic [FCNT_W-1:0] FCNT_RST = 9'd256;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_HIT     = 2'd0,
		ST_FREE    = 2'd1,
		ST_EVICT   = 2'd2,
		ST_NOFRAME = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_LOOK  = 7'b0000100,
		S_SCAN  = 7'b0001000,
		S_EVICT = 7'b0010000,
		S_FILL  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

endpackage

// File: design/tlpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_if
// Access and result channels of the page translator (valid/ready).
// ----------------------------------------------------------------------------
interface tlpt_in_if;
	logic                         valid;
	logic                         ready;
	logic [tlpt_pkg::VA_W-1:0]    virt_addr;
	logic                         mode;

	modport source (output valid, virt_addr, mode, input ready);
	modport sink   (input valid, virt_addr, mode, output ready);
endinterface

interface tlpt_out_if;
	logic                         valid;
	logic                         ready;
	logic [tlpt_pkg::VA_W-1:0]    phys_addr;
	tlpt_pkg::status_t            status;
	logic [tlpt_pkg::CNT_W-1:0]   read_total;
	logic [tlpt_pkg::CNT_W-1:0]   write_total;
	logic [tlpt_pkg::CNT_W-1:0]   fault_total;
	logic [tlpt_pkg::CNT_W-1:0]   evict_total;

	modport source (output valid, phys_addr, status, read_total, write_total,
		fault_total, evict_total, input ready);
	modport sink   (input valid, phys_addr, status, read_total, write_total,
		fault_total, evict_total, output ready);
endinterface

// File: design/tlpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/two_level_page_translate_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_translate_lru
// Page translation with a flat page table and least-recently-used eviction.
// ----------------------------------------------------------------------------
// One access at a time. A hit or a fault served from a free frame goes
// from LOOK straight to DONE; a fault with eviction walks the frame
// table through its one read port, one frame per cycle, in SCAN, then
// clears the victim's page entry in EVICT and maps the page in FILL. After
// reset and after every write to the offset, level or frame count register
// the page table is swept clear, one entry per cycle, over all
// 2**PAGE_INDEX_BITS entries (1048576 by default); no access is taken during
// the sweep. A result waits in an output register while the next access is translated.
// ----------------------------------------------------------------------------
module two_level_page_translate_lru #(
	parameter int PAGE_INDEX_BITS = 20,
	parameter int MAX_FRAMES      = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tlpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlpt_pkg::CFG_W-1:0]        cfg_data,
	tlpt_in_if.sink                           in_ch,
	tlpt_out_if.source                        out_ch
);

	localparam int PIB     = PAGE_INDEX_BITS;
	localparam int FW      = $clog2(MAX_FRAMES);
	localparam int CW      = $clog2(MAX_FRAMES + 1);
	localparam int PDEPTH  = 1 << PIB;
	localparam int PG_W    = 1 + FW;
	localparam int FR_W    = tlpt_pkg::STAMP_W + PIB;
	localparam int VA_W    = tlpt_pkg::VA_W;
	localparam int CNT_W   = tlpt_pkg::CNT_W;

	tlpt_pkg::state_t                 state_q;
	logic [tlpt_pkg::OFF_W-1:0]       off_bits_q;
	logic [tlpt_pkg::LVL_W-1:0]       lvl_bits_q;
	logic [tlpt_pkg::FCNT_W-1:0]      fcnt_q;

	logic [PIB-1:0]                   clr_q;
	logic [CW-1:0]                    free_left_q;
	logic [tlpt_pkg::STAMP_W-1:0]     clock_q;
	logic [CNT_W-1:0]                 reads_q, writes_q, faults_q, evicts_q;

	logic [PIB-1:0]                   page_q;
	logic [VA_W-1:0]                  poff_q;
	logic [FW-1:0]                    frame_q;
	tlpt_pkg::status_t                status_q;

	logic [CW-1:0]                    rd_idx_q;
	logic [FW-1:0]                    cmp_idx_q;
	logic [tlpt_pkg::STAMP_W-1:0]     best_stamp_q;
	logic [PIB-1:0]                   best_owner_q;

	logic                             out_valid_q;
	logic [VA_W-1:0]                  out_phys_q;
	tlpt_pkg::status_t                out_status_q;
	logic [CNT_W-1:0]                 out_rd_q, out_wr_q, out_flt_q, out_ev_q;

	// usable frames = min(frame_count, MAX_FRAMES)
	logic [CW-1:0] usable;
	always_comb begin
		if (32'(fcnt_q) > 32'(MAX_FRAMES)) begin
			usable = CW'(MAX_FRAMES);
		end else begin
			usable = CW'(fcnt_q);
		end
	end

	// address split
	logic [VA_W-1:0] lmask, first_idx, second_idx, page_full, poff;
	logic [5:0]      hi_shift;
	always_comb begin
		lmask      = (32'd1 << lvl_bits_q) - 32'd1;
		hi_shift   = 6'(off_bits_q) + 6'(lvl_bits_q);
		first_idx  = (in_ch.virt_addr >> hi_shift) & lmask;
		second_idx = (in_ch.virt_addr >> off_bits_q) & lmask;
		page_full  = (first_idx << lvl_bits_q) | second_idx;
		poff       = in_ch.virt_addr & ((32'd1 << off_bits_q) - 32'd1);
	end

	logic in_xfer, out_xfer, out_free;
	assign in_ch.ready = (state_q == tlpt_pkg::S_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_xfer    = out_valid_q && out_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// memories
	logic            pg_we;
	logic [PIB-1:0]  pg_waddr, pg_raddr;
	logic [PG_W-1:0] pg_wdata, pg_rdata;
	logic            fr_we;
	logic [FW-1:0]   fr_waddr, fr_raddr;
	logic [FR_W-1:0] fr_wdata, fr_rdata;

	tlpt_ram #(.WIDTH(PG_W), .DEPTH(PDEPTH)) u_page_ram (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (pg_wdata),
		.raddr (pg_raddr),
		.rdata (pg_rdata)
	);

	tlpt_ram #(.WIDTH(FR_W), .DEPTH(MAX_FRAMES)) u_frame_ram (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	logic                         pg_hit;
	logic [FW-1:0]                pg_frame, free_frame;
	logic [tlpt_pkg::STAMP_W-1:0] rd_stamp;
	logic [PIB-1:0]               rd_owner;
	logic                         take_best, scan_last;

	assign pg_hit     = pg_rdata[FW];
	assign pg_frame   = pg_rdata[FW-1:0];
	assign free_frame = FW'(free_left_q - CW'(1));
	assign rd_stamp   = fr_rdata[FR_W-1:PIB];
	assign rd_owner   = fr_rdata[PIB-1:0];
	assign take_best  = (cmp_idx_q == '0) || (rd_stamp < best_stamp_q);
	assign scan_last  = (CW'(cmp_idx_q) == usable - CW'(1));

	always_comb begin
		pg_we    = 1'b0;
		pg_waddr = page_q;
		pg_wdata = {1'b1, frame_q};
		pg_raddr = page_full[PIB-1:0];
		fr_we    = 1'b0;
		fr_waddr = frame_q;
		fr_wdata = {clock_q, page_q};
		fr_raddr = rd_idx_q[FW-1:0];
		unique case (state_q)
			tlpt_pkg::S_CLEAR: begin
				pg_we    = 1'b1;
				pg_waddr = clr_q;
				pg_wdata = '0;
			end
			tlpt_pkg::S_LOOK: begin
				fr_raddr = '0;
				if (pg_hit) begin
					fr_we    = 1'b1;
					fr_waddr = pg_frame;
				end else if (free_left_q != '0) begin
					pg_we    = 1'b1;
					pg_wdata = {1'b1, free_frame};
					fr_we    = 1'b1;
					fr_waddr = free_frame;
				end
			end
			tlpt_pkg::S_EVICT: begin
				pg_we    = 1'b1;
				pg_waddr = best_owner_q;
				pg_wdata = '0;
			end
			tlpt_pkg::S_FILL: begin
				pg_we = 1'b1;
				fr_we = 1'b1;
			end
			tlpt_pkg::S_IDLE, tlpt_pkg::S_SCAN, tlpt_pkg::S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + CNT_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlpt_pkg::S_CLEAR;
			off_bits_q  <= tlpt_pkg::OFF_RST;
			lvl_bits_q  <= tlpt_pkg::LVL_RST;
			fcnt_q      <= tlpt_pkg::FCNT_RST;
			clr_q       <= '0;
			free_left_q <= '0;
			clock_q     <= '0;
			reads_q     <= '0;
			writes_q    <= '0;
			faults_q    <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in DONE the output register is reloaded below instead
			if (out_xfer && (cfg_we || state_q != tlpt_pkg::S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && (cfg_index == tlpt_pkg::REG_OFFSET_BITS ||
					cfg_index == tlpt_pkg::REG_LEVEL_BITS ||
					cfg_index == tlpt_pkg::REG_FRAME_COUNT)) begin
				unique case (cfg_index)
					tlpt_pkg::REG_OFFSET_BITS: off_bits_q <= cfg_data[tlpt_pkg::OFF_W-1:0];
					tlpt_pkg::REG_LEVEL_BITS:  lvl_bits_q <= cfg_data[tlpt_pkg::LVL_W-1:0];
					default:                   fcnt_q     <= cfg_data;
				endcase
				state_q <= tlpt_pkg::S_CLEAR;
				clr_q   <= '0;
			end else begin
				unique case (state_q)
					tlpt_pkg::S_CLEAR: begin
						// restart: counters and free pool follow the live registers
						free_left_q <= usable;
						clock_q     <= '0;
						reads_q     <= '0;
						writes_q    <= '0;
						faults_q    <= '0;
						evicts_q    <= '0;
						clr_q       <= clr_q + PIB'(1);
						if (clr_q == '1) begin
							state_q <= tlpt_pkg::S_IDLE;
						end
					end
					tlpt_pkg::S_IDLE: begin
						if (in_xfer) begin
							if (in_ch.mode) begin
								writes_q <= sat_inc(writes_q);
							end else begin
								reads_q <= sat_inc(reads_q);
							end
							clock_q <= clock_q + tlpt_pkg::STAMP_W'(1);
							state_q <= tlpt_pkg::S_LOOK;
						end
					end
					tlpt_pkg::S_LOOK: begin
						if (pg_hit) begin
							state_q <= tlpt_pkg::S_DONE;
						end else begin
							faults_q <= sat_inc(faults_q);
							if (free_left_q != '0) begin
								free_left_q <= free_left_q - CW'(1);
								state_q     <= tlpt_pkg::S_DONE;
							end else if (usable == '0) begin
								state_q <= tlpt_pkg::S_DONE;
							end else begin
								state_q <= tlpt_pkg::S_SCAN;
							end
						end
					end
					tlpt_pkg::S_SCAN: begin
						if (scan_last) begin
							state_q <= tlpt_pkg::S_EVICT;
						end
					end
					tlpt_pkg::S_EVICT: begin
						state_q <= tlpt_pkg::S_FILL;
					end
					tlpt_pkg::S_FILL: begin
						evicts_q <= sat_inc(evicts_q);
						state_q  <= tlpt_pkg::S_DONE;
					end
					tlpt_pkg::S_DONE: begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							state_q     <= tlpt_pkg::S_IDLE;
						end
					end
					default: state_q <= tlpt_pkg::S_CLEAR;
				endcase
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			tlpt_pkg::S_IDLE: begin
				page_q <= page_full[PIB-1:0];
				poff_q <= poff;
			end
			tlpt_pkg::S_LOOK: begin
				rd_idx_q  <= CW'(1);
				cmp_idx_q <= '0;
				if (pg_hit) begin
					frame_q  <= pg_frame;
					status_q <= tlpt_pkg::ST_HIT;
				end else if (free_left_q != '0) begin
					frame_q  <= free_frame;
					status_q <= tlpt_pkg::ST_FREE;
				end else if (usable == '0) begin
					status_q <= tlpt_pkg::ST_NOFRAME;
				end else begin
					status_q <= tlpt_pkg::ST_EVICT;
				end
			end
			tlpt_pkg::S_SCAN: begin
				// strict compare keeps the lowest frame on a stamp tie
				if (take_best) begin
					best_stamp_q <= rd_stamp;
					best_owner_q <= rd_owner;
					frame_q      <= cmp_idx_q;
				end
				if (rd_idx_q < usable) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				cmp_idx_q <= cmp_idx_q + FW'(1);
			end
			tlpt_pkg::S_DONE: begin
				if (out_free) begin
					out_phys_q   <= (status_q == tlpt_pkg::ST_NOFRAME) ? '0 :
						(VA_W'(frame_q) << off_bits_q) + poff_q;
					out_status_q <= status_q;
					out_rd_q     <= reads_q;
					out_wr_q     <= writes_q;
					out_flt_q    <= faults_q;
					out_ev_q     <= evicts_q;
				end
			end
			tlpt_pkg::S_CLEAR, tlpt_pkg::S_EVICT, tlpt_pkg::S_FILL: begin
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.phys_addr   = out_phys_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.read_total  = out_rd_q;
	assign out_ch.write_total = out_wr_q;
	assign out_ch.fault_total = out_flt_q;
	assign out_ch.evict_total = out_ev_q;

	// free pool never grows past the usable frames outside a restart
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tlpt_pkg::S_CLEAR) |-> (free_left_q <= usable))
		else $error("free frame count above usable frames");

	// an eviction is only reported once the free pool is empty
	a_evict_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlpt_pkg::S_DONE && status_q == tlpt_pkg::ST_EVICT)
		|-> (free_left_q == '0))
		else $error("eviction with free frames left");

	// the stamp walk writes neither the page table nor the frame table
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlpt_pkg::S_SCAN) |-> (!pg_we && !fr_we))
		else $error("table write during stamp walk");

	// an accepted access goes straight to the table lookup
	a_look_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !cfg_we) |=> (state_q == tlpt_pkg::S_LOOK))
		else $error("lookup did not follow access transfer");

endmodule

// File: tb/sv/tlpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_checker
// Watches the access and result channels of the page translator, predicts
// each result from its own copy of the page table, frame stamps and
// counters, and compares field by field.
// ----------------------------------------------------------------------------
module tlpt_checker #(
	parameter int PIB  = 20,
	parameter int MAXF = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tlpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlpt_pkg::CFG_W-1:0]     cfg_data,
	tlpt_in_if                             acc,
	tlpt_out_if                            res,
	output int                             errors,
	output int                             waiting,
	output int                             n_results,
	output int                             n_evict,
	output int                             n_noframe
);

	typedef struct {
		logic [31:0]       phys;
		tlpt_pkg::status_t st;
		logic [31:0]       rd, wr, flt, ev;
	} xlate_t;

	xlate_t           pending_q[$];
	logic [4:0]       off_r;
	logic [3:0]       lvl_r;
	logic [8:0]       fc_r;
	bit               pvalid[1 << PIB];
	int unsigned      pframe[1 << PIB];
	int unsigned      owner[MAXF];
	longint unsigned  stamp[MAXF];
	int unsigned      free_left;
	longint unsigned  tick;
	logic [31:0]      c_rd, c_wr, c_flt, c_ev;

	function automatic int unsigned usable_frames();
		return (fc_r > MAXF) ? MAXF : fc_r;
	endfunction

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 1;
	endfunction

	function automatic void restart();
		for (int i = 0; i < (1 << PIB); i++) begin
			pvalid[i] = 0;
			pframe[i] = 0;
		end
		for (int i = 0; i < MAXF; i++) begin
			owner[i] = 0;
			stamp[i] = 0;
		end
		free_left = usable_frames();
		tick = 0;
		c_rd = 0;
		c_wr = 0;
		c_flt = 0;
		c_ev = 0;
	endfunction

	function automatic xlate_t translate(logic [31:0] va_in, logic wr_mode);
		xlate_t            r;
		longint unsigned   va, lmask, first, second, poff;
		int unsigned       page, frame, use_n;
		tlpt_pkg::status_t st;
		va = va_in;
		lmask = (64'd1 << lvl_r) - 1;
		first = (va >> (int'(off_r) + int'(lvl_r))) & lmask;
		second = (va >> off_r) & lmask;
		poff = va & ((64'd1 << off_r) - 1);
		page = ((first << lvl_r) | second) & ((64'd1 << PIB) - 1);
		frame = 0;
		if (wr_mode)
			c_wr = sat_inc(c_wr);
		else
			c_rd = sat_inc(c_rd);
		tick++;
		if (pvalid[page]) begin
			frame = pframe[page] % MAXF;
			stamp[frame] = tick;
			st = tlpt_pkg::ST_HIT;
		end else begin
			use_n = usable_frames();
			c_flt = sat_inc(c_flt);
			if (free_left > 0) begin
				free_left--;
				frame = free_left % MAXF;
				st = tlpt_pkg::ST_FREE;
			end else if (use_n == 0) begin
				st = tlpt_pkg::ST_NOFRAME;
			end else begin
				// oldest stamp wins, lowest frame on a tie
				for (int i = 1; i < use_n; i++)
					if (stamp[i] < stamp[frame])
						frame = i;
				pvalid[owner[frame] & ((1 << PIB) - 1)] = 0;
				c_ev = sat_inc(c_ev);
				st = tlpt_pkg::ST_EVICT;
			end
			if (st != tlpt_pkg::ST_NOFRAME) begin
				pvalid[page] = 1;
				pframe[page] = frame;
				owner[frame] = page;
				stamp[frame] = tick;
			end
		end
		r.phys = (st == tlpt_pkg::ST_NOFRAME) ? 32'd0 :
			32'(((64'(frame)) << off_r) + poff);
		r.st = st;
		r.rd = c_rd;
		r.wr = c_wr;
		r.flt = c_flt;
		r.ev = c_ev;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH result %0d %s: got %h expected %h", n_results, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		xlate_t e;
		bit     hit_reg;
		if (!arst_n) begin
			off_r = tlpt_pkg::OFF_RST;
			lvl_r = tlpt_pkg::LVL_RST;
			fc_r = tlpt_pkg::FCNT_RST;
			restart();
			pending_q.delete();
			errors = 0;
			n_results = 0;
			n_evict = 0;
			n_noframe = 0;
		end else begin
			if (cfg_we) begin
				hit_reg = 1;
				case (cfg_index)
					tlpt_pkg::REG_OFFSET_BITS: off_r = cfg_data[4:0];
					tlpt_pkg::REG_LEVEL_BITS:  lvl_r = cfg_data[3:0];
					tlpt_pkg::REG_FRAME_COUNT: fc_r = cfg_data[8:0];
					default:                   hit_reg = 0;
				endcase
				if (hit_reg)
					restart();
			end
			if (acc.valid && acc.ready)
				pending_q.push_back(translate(acc.virt_addr, acc.mode));
			if (res.valid && res.ready) begin
				if (pending_q.size() == 0) begin
					$display("MISMATCH unexpected result, phys %h", res.phys_addr);
					errors++;
				end else begin
					e = pending_q.pop_front();
					if (res.phys_addr !== e.phys) report("phys_addr", res.phys_addr, e.phys);
					if (res.status !== e.st) report("status", 32'(res.status), 32'(e.st));
					if (res.read_total !== e.rd) report("read_total", res.read_total, e.rd);
					if (res.write_total !== e.wr) report("write_total", res.write_total, e.wr);
					if (res.fault_total !== e.flt) report("fault_total", res.fault_total, e.flt);
					if (res.evict_total !== e.ev) report("evict_total", res.evict_total, e.ev);
					if (e.st == tlpt_pkg::ST_EVICT) n_evict++;
					if (e.st == tlpt_pkg::ST_NOFRAME) n_noframe++;
				end
				n_results++;
			end
		end
		waiting = pending_q.size();
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives accesses and register settings into the page translator under
// rotating idle/stall patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

	// reduced page table keeps the clearing sweep short
	localparam int  PIB   = 12;
	localparam int  MAXF  = 256;
	localparam longint LIMIT = 3_000_000;

	logic                           clk = 0;
	logic                           arst_n = 0;
	logic                           cfg_we = 0;
	logic [tlpt_pkg::CFG_IDX_W-1:0] cfg_index = tlpt_pkg::REG_OFFSET_BITS;
	logic [tlpt_pkg::CFG_W-1:0]     cfg_data = 0;
	int                             errors, waiting, n_results, n_evict, n_noframe;
	int                             idle_mode = 0;
	longint                         cyc = 0;
	logic [4:0]                     cur_off = tlpt_pkg::OFF_RST;

	tlpt_in_if  acc();
	tlpt_out_if res();

	two_level_page_translate_lru #(.PAGE_INDEX_BITS(PIB), .MAX_FRAMES(MAXF)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(acc), .out_ch(res)
	);

	tlpt_checker #(.PIB(PIB), .MAXF(MAXF)) chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .acc(acc), .res(res), .errors(errors),
		.waiting(waiting), .n_results(n_results), .n_evict(n_evict),
		.n_noframe(n_noframe)
	);

	always #1 clk = ~clk;

	// result side: stall in modes 2 (46%) and 3 (7%)
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 0;
		end else begin
			case (idle_mode)
				2:       res.ready <= ($urandom_range(0, 99) >= 46);
				3:       res.ready <= ($urandom_range(0, 99) >= 7);
				default: res.ready <= 1;
			endcase
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("two_level_page_translate_lru test failed");
			$finish;
		end
	end

	task automatic send(logic [31:0] va, logic m);
		int p, n;
		p = (idle_mode == 1) ? 46 : (idle_mode == 3) ? 7 : 0;
		n = 0;
		while (n < 20 && $urandom_range(0, 99) < p)
			n++;
		if (n > 0) begin
			acc.valid <= 0;
			repeat (n) @(posedge clk);
		end
		acc.valid <= 1;
		acc.virt_addr <= va;
		acc.mode <= m;
		do @(posedge clk); while (!acc.ready);
	endtask

	task automatic drain();
		acc.valid <= 0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		// let an eviction walk finish before touching registers
		repeat (300) @(posedge clk);
	endtask

	task automatic set_regs(logic [4:0] o, logic [3:0] l, logic [8:0] f);
		drain();
		cfg_we <= 1;
		cfg_index <= tlpt_pkg::REG_OFFSET_BITS;
		cfg_data <= 9'(o);
		@(posedge clk);
		cfg_index <= tlpt_pkg::REG_LEVEL_BITS;
		cfg_data <= 9'(l);
		@(posedge clk);
		cfg_index <= tlpt_pkg::REG_FRAME_COUNT;
		cfg_data <= f;
		@(posedge clk);
		cfg_we <= 0;
		cur_off = o;
	endtask

	function automatic logic [31:0] page_addr(int unsigned pg);
		longint unsigned a;
		a = (longint'(pg) << cur_off) | ($urandom() & ((64'd1 << cur_off) - 1));
		return a[31:0];
	endfunction

	initial begin
		int unsigned pool[$];
		int unsigned np, fsel;
		logic [8:0]  fc;
		acc.valid <= 0;
		acc.virt_addr <= 0;
		acc.mode <= 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// defaults: extremes of the address and both modes
		send(32'h0000_0000, 0);
		send(32'hFFFF_FFFF, 1);
		send(32'h0000_0FFF, 0);
		send(32'h0000_1234, 1);
		send(32'hFFFF_F000, 0);
		send(32'hAAAA_AAAA, 1);
		send(32'h5555_5555, 0);

		// no frame at all, offset 10 and level 1
		set_regs(5'd10, 4'd1, 9'd0);
		send(32'h0000_0000, 0);
		send(32'hFFFF_FFFF, 1);
		send(32'h0000_0C00, 0);

		// two frames: evictions in least-recently-used order
		set_regs(5'd10, 4'd1, 9'd2);
		for (int i = 0; i < 7; i++)
			send(page_addr((i * 3 + i / 2) & 3), i[0]);

		// out-of-range widths and a frame count above the table limit
		set_regs(5'd31, 4'd15, 9'd511);
		send(32'hFFFF_FFFF, 0);
		send(32'h8000_0000, 1);
		send(32'h7FFF_FFFF, 0);
		set_regs(5'd22, 4'd10, 9'd256);
		send(32'hFFFF_FFFF, 1);
		send(32'h0040_0000, 0);

		for (int ph = 0; ph < 8; ph++) begin
			fsel = $urandom_range(0, 9);
			fc = (fsel < 6) ? 9'($urandom_range(1, 8)) : (fsel == 6) ? 9'd0 :
				(fsel == 7) ? 9'd256 : 9'($urandom_range(9, 40));
			if ($urandom_range(0, 4) == 0)
				set_regs(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)), fc);
			else
				set_regs(5'($urandom_range(10, 22)), 4'($urandom_range(1, 10)), fc);
			pool.delete();
			np = (fc > 40 ? 40 : fc) + $urandom_range(1, 4);
			for (int i = 0; i < np; i++)
				pool.push_back($urandom());
			for (int k = 0; k < 125; k++) begin
				idle_mode = (k / 40 + ph) % 4;
				if ($urandom_range(0, 99) < 80)
					send(page_addr(pool[$urandom_range(0, np - 1)]),
						1'($urandom_range(0, 1)));
				else
					send($urandom(), 1'($urandom_range(0, 1)));
			end
		end

		idle_mode = 0;
		drain();
		$display("Covered %0d results: %0d evictions, %0d with no frame, 12 settings.",
			n_results, n_evict, n_noframe);
		if (errors == 0)
			$display("two_level_page_translate_lru test passed");
		else
			$display("two_level_page_translate_lru test failed");
		$finish;
	end

endmodule
